// ----- src/multichannel_pcm_mixer_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the PCM mixer
// Short forms for the concurrent checks used across the RTL. Each one samples
// on clk and is disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_PCM_MIXER_MACROS_SVH
`define MULTICHANNEL_PCM_MIXER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pmx_pkg.sv -----
// ---------------------------------------------------------------------------
// PCM mixer package
// Beat payload types, configuration and frame records, and item codes.
// ---------------------------------------------------------------------------
package pmx_pkg;

  // Item kinds
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_SET   = 3'd2;
  localparam logic [2:0] KIND_STOP  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SIXTEEN_BIT = 2'd0;
  localparam logic [1:0] CFG_SIGNED      = 2'd1;
  localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd2;
  localparam logic [1:0] CFG_CHANNELS    = 2'd3;

  localparam int MASK_W = 8;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         voice;
    logic [15:0]        address;
    logic signed [15:0] sample_word;
    logic [16:0]        sound_length;
    logic [6:0]         volume;
    logic [7:0]         separation;
  } in_t;

  typedef struct packed {
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic [1:0]        output_channel;
    logic              last_of_frame;
    logic [MASK_W-1:0] playing_mask;
  } out_t;

  typedef struct packed {
    logic       sixteen_bit_output;
    logic       signed_output;
    logic       big_endian_output;
    logic [2:0] output_channel_count;
  } cfg_t;

  // Finished frame, already saturated to 16 bits
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [MASK_W-1:0]  mask;
  } frame_t;

  typedef enum logic [1:0] {
    OP_MIX_L  = 2'd0,
    OP_MIX_R  = 2'd1,
    OP_GAIN_L = 2'd2,
    OP_GAIN_R = 2'd3
  } mac_op_t;

  typedef struct packed {
    logic               go;
    mac_op_t            op;
    logic signed [16:0] a;
    logic [7:0]         b;
  } mac_req_t;

  typedef struct packed {
    logic       valid;
    logic       right;
    logic [7:0] gain;
  } gain_wr_t;

endpackage

// ----- src/pmx_mac.sv -----
// ---------------------------------------------------------------------------
// PCM mixer shared multiply unit
// One 17x9 multiplier with a constant-divide stage behind it. Mix products
// are scaled by 1/255 toward zero and summed; gain products are scaled by
// 1/127 and handed back.
// ---------------------------------------------------------------------------
module pmx_mac import pmx_pkg::*; #(
  parameter int ACC_W = 21
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  mac_req_t           req,
  output logic               busy,
  output gain_wr_t           gain_wr,
  output logic signed [15:0] left,
  output logic signed [15:0] right
);

  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // floor(m/255), m <= 255*32768: reciprocal estimate is at most one low
  function automatic logic [15:0] div255(input logic [22:0] m);
    logic [30:0] t;
    logic [14:0] est;
    logic [23:0] r;
    t      = 31'(m) + {m, 8'd0};
    est    = t[30:16];
    r      = 24'(m) - ({1'b0, est, 8'd0} - 24'(est));
    div255 = (r >= 24'd255) ? 16'(est) + 16'd1 : 16'(est);
  endfunction

  // floor(x/127), x <= 255*127
  function automatic logic [7:0] div127(input logic [14:0] x);
    logic [23:0] t;
    logic [7:0]  est;
    logic [15:0] r;
    t      = {x, 9'd0} + 24'({x, 2'd0});
    est    = t[23:16];
    r      = 16'(x) - ({1'b0, est, 7'd0} - 16'(est));
    div127 = (r >= 16'd127) ? est + 8'd1 : est;
  endfunction

  logic signed [25:0] p1;
  mac_op_t            op1;
  logic               v1;
  logic signed [16:0] q2;
  mac_op_t            op2;
  logic               v2;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  logic [25:0]        p_abs;
  logic [15:0]        q_mag;

  assign p_abs = p1[25] ? 26'(-p1) : 26'(p1);
  assign q_mag = div255(p_abs[22:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.go;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p1  <= req.a * $signed({1'b0, req.b});
    op1 <= req.op;
    op2 <= op1;
    if (op1 == OP_GAIN_L || op1 == OP_GAIN_R) begin
      q2 <= 17'(div127(p1[14:0]));
    end else begin
      q2 <= p1[25] ? -17'(q_mag) : 17'(q_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (v2) begin
      if (op2 == OP_MIX_L) acc_l <= acc_l + ACC_W'(q2);
      if (op2 == OP_MIX_R) acc_r <= acc_r + ACC_W'(q2);
    end
  end

  assign busy          = v1 | v2;
  assign gain_wr.valid = v2 && (op2 == OP_GAIN_L || op2 == OP_GAIN_R);
  assign gain_wr.right = (op2 == OP_GAIN_R);
  assign gain_wr.gain  = q2[7:0];

  always_comb begin
    priority if (acc_l > ACC_W'(SAT_MAX)) left = 16'(SAT_MAX);
    else if (acc_l < ACC_W'(SAT_MIN))     left = 16'(SAT_MIN);
    else                                  left = acc_l[15:0];
    priority if (acc_r > ACC_W'(SAT_MAX)) right = 16'(SAT_MAX);
    else if (acc_r < ACC_W'(SAT_MIN))     right = 16'(SAT_MIN);
    else                                  right = acc_r[15:0];
  end

endmodule

// ----- src/pmx_emit.sv -----
// ---------------------------------------------------------------------------
// PCM mixer output emitter
// Holds one finished frame and sends one formatted beat per output channel.
// ---------------------------------------------------------------------------
`include "multichannel_pcm_mixer_macros.svh"

module pmx_emit import pmx_pkg::*; #(
  parameter int MAX_OUTPUTS = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   frame_go,
  input  frame_t frame,
  output logic   ready,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  localparam int CNW = $clog2(MAX_OUTPUTS + 1);

  logic               busy;
  logic [CNW-1:0]     k;
  logic [CNW-1:0]     cnt;
  logic [CNW-1:0]     cnt_eff;
  frame_t             frm;
  logic signed [16:0] sum;
  logic signed [16:0] sum_adj;
  logic signed [16:0] avg_wide;
  logic signed [15:0] smp;
  logic [15:0]        u;
  logic               last;
  logic               beat;

  always_comb begin
    priority if (cfg.output_channel_count == 3'd0) cnt_eff = CNW'(1);
    else if (int'(cfg.output_channel_count) > MAX_OUTPUTS) cnt_eff = CNW'(MAX_OUTPUTS);
    else cnt_eff = CNW'(cfg.output_channel_count);
  end

  // average truncated toward zero
  assign sum      = 17'(frm.left) + 17'(frm.right);
  assign sum_adj  = sum + $signed({16'd0, sum[16]});
  assign avg_wide = sum_adj >>> 1;

  always_comb begin
    priority if (cnt == CNW'(1)) smp = avg_wide[15:0];
    else if (k == CNW'(0))       smp = frm.left;
    else if (k == CNW'(1))       smp = frm.right;
    else                         smp = avg_wide[15:0];
  end

  assign u    = cfg.signed_output ? smp : (smp ^ 16'h8000);
  assign last = (k + CNW'(1) == cnt);
  assign beat = out_valid && !out_stall;

  always_comb begin
    priority if (!cfg.sixteen_bit_output) begin
      out_data.first_byte  = u[15:8];
      out_data.second_byte = 8'd0;
    end else if (cfg.big_endian_output) begin
      out_data.first_byte  = u[15:8];
      out_data.second_byte = u[7:0];
    end else begin
      out_data.first_byte  = u[7:0];
      out_data.second_byte = u[15:8];
    end
    out_data.output_channel = 2'(k);
    out_data.last_of_frame  = last;
    out_data.playing_mask   = frm.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
      cnt  <= CNW'(1);
    end else if (frame_go) begin
      busy <= 1'b1;
      k    <= '0;
      cnt  <= cnt_eff;
    end else if (beat) begin
      if (last) busy <= 1'b0;
      else      k    <= k + CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (frame_go) frm <= frame;
  end

  assign ready     = !busy;
  assign out_valid = busy;

  `PMX_ASSERT_NOW(a_load_when_free, frame_go, !busy, "frame loaded over a pending frame")
  `PMX_ASSERT_NEXT(a_frame_continues, beat && !last, out_valid, "frame ended early")
  `PMX_ASSERT_NOW(a_chan_in_range, busy, k < cnt, "channel index past count")

endmodule

// ----- src/multichannel_pcm_mixer.sv -----
// ---------------------------------------------------------------------------
// Multichannel PCM mixer
// Sample store, voice table and sequencer around one shared multiply unit.
// ---------------------------------------------------------------------------
// Load, stop and ignored items leave in_stall low. Start and set-params
// items are accepted, then the shared multiplier computes both pan gains
// and its pipeline drains. A set-params item for an idle voice is dropped
// and leaves in_stall low. A tick walks the voices one after another: an
// idle or retiring voice is passed over in S_VOICE, a playing voice goes
// through S_VOICE (sample memory read), S_MUL_L and S_MUL_R (left and right
// multiply on the one multiplier), and the frame then waits in S_HAND for
// the pipeline drain and handoff. The multiplier and the single read
// port of the sample store pace the tick. in_stall is high while an item
// is in work. Results of a tick go to an output stage that sends one beat
// per output channel; the block takes new items while those beats wait, and
// only the next tick waits for the output stage to be free. The sample store
// is not cleared; reading a word never loaded is undefined. SAMPLE_DEPTH is
// taken as a power of two, and store addresses wrap at it.
// ---------------------------------------------------------------------------
`include "multichannel_pcm_mixer_macros.svh"

module multichannel_pcm_mixer import pmx_pkg::*; #(
  parameter int NUM_VOICES   = 8,
  parameter int SAMPLE_DEPTH = 65536,
  parameter int MAX_OUTPUTS  = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW    = $clog2(NUM_VOICES + 1);
  localparam int ACC_W = 17 + $clog2(NUM_VOICES + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_GAIN_L = 8'b0000_0010,
    S_GAIN_R = 8'b0000_0100,
    S_GWAIT  = 8'b0000_1000,
    S_VOICE  = 8'b0001_0000,
    S_MUL_L  = 8'b0010_0000,
    S_MUL_R  = 8'b0100_0000,
    S_HAND   = 8'b1000_0000
  } state_t;

  state_t state;
  logic   drain;       // in S_HAND, still waiting for the multiplier to empty
  cfg_t   cfg;
  in_t    cur;         // item in work (start / set params)
  logic [CW-1:0] vcnt; // voice being visited during a tick

  // voice table
  logic              active [NUM_VOICES];
  logic [15:0]       base   [NUM_VOICES];
  logic [16:0]       pos    [NUM_VOICES];
  logic [16:0]       len    [NUM_VOICES];
  logic [7:0]        gl     [NUM_VOICES];
  logic [7:0]        gr     [NUM_VOICES];

  // sample store
  logic [15:0]        mem [SAMPLE_DEPTH];
  logic signed [15:0] rdata;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      rd_addr;

  logic          accept;
  logic          in_range;
  logic [VW-1:0] vi;
  logic [VW-1:0] in_v;
  logic [VW-1:0] cv;
  logic [16:0]   pos_inc;
  logic [7:0]    lsep;

  mac_req_t           req;
  logic               mac_clear;
  logic               mac_busy;
  gain_wr_t           gain_wr;
  logic signed [15:0] mix_l;
  logic signed [15:0] mix_r;
  frame_t             frame;
  logic               frame_go;
  logic               emit_ready;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign in_range = (6'(in_data.voice) < 6'(NUM_VOICES));
  assign in_v     = VW'(in_data.voice);
  assign cv       = VW'(cur.voice);
  assign vi       = vcnt[VW-1:0];
  assign pos_inc  = pos[vi] + 17'd1;

  // full left at separation 0, no left at all from 254 up
  assign lsep = (cur.separation == 8'd255) ? 8'd0 : 8'd254 - cur.separation;

  assign mem_we    = accept && (in_data.kind == KIND_LOAD);
  assign mac_clear = accept && (in_data.kind == KIND_TICK);

  // fetch only for a playing voice that still has samples left
  assign mem_re  = (state == S_VOICE) && (vcnt != CW'(NUM_VOICES)) &&
                   active[vi] && (pos[vi] < len[vi]);
  assign rd_addr = AW'(18'(base[vi]) + 18'(pos[vi]));

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(in_data.address)] <= in_data.sample_word;
    if (mem_re) rdata <= mem[rd_addr];
  end

  // Multiplier requests. The sample read in S_VOICE is held in rdata for
  // both the left and the right product.
  always_comb begin
    req = '{go: 1'b0, op: OP_MIX_L, a: '0, b: '0};
    unique case (state)
      S_GAIN_L: req = '{go: 1'b1, op: OP_GAIN_L, a: 17'(lsep), b: 8'(cur.volume)};
      S_GAIN_R: req = '{go: 1'b1, op: OP_GAIN_R, a: 17'(cur.separation),
                        b: 8'(cur.volume)};
      S_MUL_L:  req = '{go: 1'b1, op: OP_MIX_L, a: 17'(rdata), b: gl[vi]};
      S_MUL_R:  req = '{go: 1'b1, op: OP_MIX_R, a: 17'(rdata), b: gr[vi]};
      S_IDLE, S_GWAIT, S_VOICE, S_HAND: ;
      default: ;
    endcase
  end

  // playing mask reports the first eight voices only
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < NUM_VOICES) begin : g_on
      assign frame.mask[g] = active[g];
    end else begin : g_off
      assign frame.mask[g] = 1'b0;
    end
  end
  assign frame.left  = mix_l;
  assign frame.right = mix_r;
  assign frame_go    = (state == S_HAND) && !drain && !mac_busy && emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= 1'b0;
      vcnt  <= '0;
      cfg   <= '{sixteen_bit_output: 1'b0, signed_output: 1'b0,
                 big_endian_output: 1'b0, output_channel_count: 3'd1};
      for (int v = 0; v < NUM_VOICES; v++) begin
        active[v] <= 1'b0;
        base[v]   <= '0;
        pos[v]    <= '0;
        len[v]    <= '0;
        gl[v]     <= 8'd255;
        gr[v]     <= 8'd255;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SIXTEEN_BIT: cfg.sixteen_bit_output   <= cfg_data[0];
          CFG_SIGNED:      cfg.signed_output        <= cfg_data[0];
          CFG_BIG_ENDIAN:  cfg.big_endian_output    <= cfg_data[0];
          CFG_CHANNELS:    cfg.output_channel_count <= cfg_data;
        endcase
      end

      if (gain_wr.valid) begin
        if (gain_wr.right) gr[cv] <= gain_wr.gain;
        else               gl[cv] <= gain_wr.gain;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur <= in_data;
            unique case (in_data.kind)
              KIND_START: begin
                if (in_range) begin
                  active[in_v] <= 1'b1;
                  base[in_v]   <= in_data.address;
                  pos[in_v]    <= '0;
                  len[in_v]    <= in_data.sound_length;
                  state        <= S_GAIN_L;
                end
              end
              KIND_SET: begin
                // set params on an idle voice is dropped
                if (in_range && active[in_v]) state <= S_GAIN_L;
              end
              KIND_STOP: begin
                if (in_range) begin
                  active[in_v] <= 1'b0;
                  pos[in_v]    <= '0;
                end
              end
              KIND_TICK: begin
                vcnt  <= '0;
                state <= S_VOICE;
              end
              default: ;   // loads go straight to memory; kinds 5-7 do nothing
            endcase
          end
        end
        S_GAIN_L: state <= S_GAIN_R;
        S_GAIN_R: state <= S_GWAIT;
        S_GWAIT:  if (!mac_busy) state <= S_IDLE;
        S_VOICE: begin
          if (vcnt == CW'(NUM_VOICES)) begin
            drain <= 1'b1;
            state <= S_HAND;
          end else if (!active[vi]) begin
            vcnt <= vcnt + CW'(1);
          end else if (pos[vi] >= len[vi]) begin
            // ran out before this frame (zero length): retire, no sample
            active[vi] <= 1'b0;
            pos[vi]    <= '0;
            vcnt       <= vcnt + CW'(1);
          end else begin
            if (pos_inc >= len[vi]) begin
              active[vi] <= 1'b0;
              pos[vi]    <= '0;
            end else begin
              pos[vi] <= pos_inc;
            end
            state <= S_MUL_L;
          end
        end
        S_MUL_L: state <= S_MUL_R;
        S_MUL_R: begin
          vcnt  <= vcnt + CW'(1);
          state <= S_VOICE;
        end
        S_HAND: begin
          // wait for the last products to land, then for the output stage
          if (drain) begin
            if (!mac_busy) drain <= 1'b0;
          end else if (frame_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pmx_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .clear   (mac_clear),
    .req     (req),
    .busy    (mac_busy),
    .gain_wr (gain_wr),
    .left    (mix_l),
    .right   (mix_r)
  );

  pmx_emit #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .frame_go  (frame_go),
    .frame     (frame),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `PMX_ASSERT_NOW(a_idle_mac_empty, state == S_IDLE, !mac_busy, "multiplier busy while idle")
  `PMX_ASSERT_NEXT(a_read_then_mul, mem_re, state == S_MUL_L, "sample read without multiply")
  `PMX_ASSERT_NOW(a_gain_in_wait, gain_wr.valid, state == S_GWAIT, "gain written outside gain wait")

endmodule
